// File: src/midec_pkg.sv
// ----------------------------------------------------------------------------
// midec_pkg: shared types and codes for the MIPS32 instruction decoder
// Opcode, function and REGIMM codes, mnemonic and operand-form codes, and
// the decoded record passed between the decoder parts.
// ----------------------------------------------------------------------------
package midec_pkg;

  // Primary opcodes (instruction bits 31:26)
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LH      = 6'd33;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_LHU     = 6'd37;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  // SPECIAL function codes (instruction bits 5:0)
  localparam logic [5:0] FN_SLL     = 6'd0;
  localparam logic [5:0] FN_SRL     = 6'd2;
  localparam logic [5:0] FN_SRA     = 6'd3;
  localparam logic [5:0] FN_SLLV    = 6'd4;
  localparam logic [5:0] FN_SRLV    = 6'd6;
  localparam logic [5:0] FN_JR      = 6'd8;
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_MFHI    = 6'd16;
  localparam logic [5:0] FN_MFLO    = 6'd18;
  localparam logic [5:0] FN_MULT    = 6'd24;
  localparam logic [5:0] FN_MULTU   = 6'd25;
  localparam logic [5:0] FN_DIV     = 6'd26;
  localparam logic [5:0] FN_DIVU    = 6'd27;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;
  localparam logic [5:0] FN_OR      = 6'd37;
  localparam logic [5:0] FN_XOR     = 6'd38;
  localparam logic [5:0] FN_NOR     = 6'd39;
  localparam logic [5:0] FN_SLT     = 6'd42;
  localparam logic [5:0] FN_SLTU    = 6'd43;

  // REGIMM rt codes (instruction bits 20:16)
  localparam logic [4:0] RI_BLTZ    = 5'd0;
  localparam logic [4:0] RI_BGEZ    = 5'd1;
  localparam logic [4:0] RI_BLTZAL  = 5'd16;
  localparam logic [4:0] RI_BGEZAL  = 5'd17;

  // Mnemonic codes, numbered densely
  typedef enum logic [5:0] {
    MN_SYSCALL = 6'd0,  MN_MFHI  = 6'd1,  MN_MFLO   = 6'd2,  MN_MULT   = 6'd3,
    MN_MULTU   = 6'd4,  MN_DIV   = 6'd5,  MN_DIVU   = 6'd6,  MN_ADD    = 6'd7,
    MN_ADDU    = 6'd8,  MN_SUB   = 6'd9,  MN_SUBU   = 6'd10, MN_AND    = 6'd11,
    MN_OR      = 6'd12, MN_XOR   = 6'd13, MN_NOR    = 6'd14, MN_SLT    = 6'd15,
    MN_SLTU    = 6'd16, MN_SLL   = 6'd17, MN_SRL    = 6'd18, MN_SRA    = 6'd19,
    MN_SLLV    = 6'd20, MN_SRLV  = 6'd21, MN_JR     = 6'd22, MN_BLTZ   = 6'd23,
    MN_BGEZ    = 6'd24, MN_BLTZAL = 6'd25, MN_BGEZAL = 6'd26, MN_BEQ   = 6'd27,
    MN_BNE     = 6'd28, MN_BLEZ  = 6'd29, MN_BGTZ   = 6'd30, MN_ADDI   = 6'd31,
    MN_ADDIU   = 6'd32, MN_SLTI  = 6'd33, MN_SLTIU  = 6'd34, MN_ANDI   = 6'd35,
    MN_ORI     = 6'd36, MN_XORI  = 6'd37, MN_LUI    = 6'd38, MN_LB     = 6'd39,
    MN_LH      = 6'd40, MN_LW    = 6'd41, MN_LBU    = 6'd42, MN_LHU    = 6'd43,
    MN_SB      = 6'd44, MN_SH    = 6'd45, MN_SW     = 6'd46, MN_J      = 6'd47,
    MN_JAL     = 6'd48
  } mnem_e;

  // Operand forms
  typedef enum logic [3:0] {
    FORM_NONE   = 4'd0,
    FORM_R      = 4'd1,
    FORM_RR     = 4'd2,
    FORM_RRR    = 4'd3,
    FORM_SHAMT  = 4'd4,
    FORM_R_TGT  = 4'd5,
    FORM_RR_TGT = 4'd6,
    FORM_RR_IMM = 4'd7,
    FORM_R_IMM  = 4'd8,
    FORM_MEM    = 4'd9,
    FORM_TGT    = 4'd10
  } form_e;

  localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;

  // Decoded record without the target address
  typedef struct packed {
    logic               valid;
    mnem_e              mnem;
    form_e              form;
    logic [4:0]         reg_a;
    logic [4:0]         reg_b;
    logic [4:0]         reg_c;
    logic [4:0]         shamt;
    logic signed [15:0] imm;
  } dec_rec_t;

endpackage

// File: src/midec_decode.sv
// ----------------------------------------------------------------------------
// midec_decode: opcode/funct/rt table
// Splits the instruction word into its fields and looks up mnemonic,
// operand form, the registers in listing order, shift amount and immediate.
// ----------------------------------------------------------------------------
module midec_decode (
  input  logic [31:0]          instr_word_i,
  output midec_pkg::dec_rec_t  rec_o
);
  import midec_pkg::*;

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [5:0]  fn;
  dec_rec_t    rec;

  assign op = instr_word_i[31:26];
  assign rs = instr_word_i[25:21];
  assign rt = instr_word_i[20:16];
  assign rd = instr_word_i[15:11];
  assign sa = instr_word_i[10:6];
  assign fn = instr_word_i[5:0];

  // Main lookup; unknown encodings keep the all-zero record
  always_comb begin
    rec       = '0;
    rec.mnem  = MN_SYSCALL;
    rec.form  = FORM_NONE;
    unique case (op) inside
      OP_SPECIAL: begin
        unique case (fn) inside
          FN_SYSCALL: begin rec.valid = 1'b1; rec.mnem = MN_SYSCALL; end
          FN_MFHI: begin
            rec.valid = 1'b1; rec.mnem = MN_MFHI; rec.form = FORM_R; rec.reg_a = rd;
          end
          FN_MFLO: begin
            rec.valid = 1'b1; rec.mnem = MN_MFLO; rec.form = FORM_R; rec.reg_a = rd;
          end
          FN_JR: begin
            rec.valid = 1'b1; rec.mnem = MN_JR; rec.form = FORM_R; rec.reg_a = rs;
          end
          FN_MULT, FN_MULTU, FN_DIV, FN_DIVU: begin
            rec.valid = 1'b1;
            rec.form  = FORM_RR;
            rec.reg_a = rs;
            rec.reg_b = rt;
            case (fn)
              FN_MULT:  rec.mnem = MN_MULT;
              FN_MULTU: rec.mnem = MN_MULTU;
              FN_DIV:   rec.mnem = MN_DIV;
              default:  rec.mnem = MN_DIVU;
            endcase
          end
          FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR,
          FN_SLT, FN_SLTU: begin
            rec.valid = 1'b1;
            rec.form  = FORM_RRR;
            rec.reg_a = rd;
            rec.reg_b = rs;
            rec.reg_c = rt;
            case (fn)
              FN_ADD:  rec.mnem = MN_ADD;
              FN_ADDU: rec.mnem = MN_ADDU;
              FN_SUB:  rec.mnem = MN_SUB;
              FN_SUBU: rec.mnem = MN_SUBU;
              FN_AND:  rec.mnem = MN_AND;
              FN_OR:   rec.mnem = MN_OR;
              FN_XOR:  rec.mnem = MN_XOR;
              FN_NOR:  rec.mnem = MN_NOR;
              FN_SLT:  rec.mnem = MN_SLT;
              default: rec.mnem = MN_SLTU;
            endcase
          end
          FN_SLL, FN_SRL, FN_SRA: begin
            rec.valid = 1'b1;
            rec.form  = FORM_SHAMT;
            rec.reg_a = rd;
            rec.reg_b = rt;
            rec.shamt = sa;
            case (fn)
              FN_SLL:  rec.mnem = MN_SLL;
              FN_SRL:  rec.mnem = MN_SRL;
              default: rec.mnem = MN_SRA;
            endcase
          end
          // variable shifts list the shift register last
          FN_SLLV, FN_SRLV: begin
            rec.valid = 1'b1;
            rec.form  = FORM_RRR;
            rec.reg_a = rd;
            rec.reg_b = rt;
            rec.reg_c = rs;
            rec.mnem  = (fn == FN_SLLV) ? MN_SLLV : MN_SRLV;
          end
          default: ;
        endcase
      end
      OP_REGIMM: begin
        unique case (rt) inside
          RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL: begin
            rec.valid = 1'b1;
            rec.form  = FORM_R_TGT;
            rec.reg_a = rs;
            case (rt)
              RI_BLTZ:   rec.mnem = MN_BLTZ;
              RI_BGEZ:   rec.mnem = MN_BGEZ;
              RI_BLTZAL: rec.mnem = MN_BLTZAL;
              default:   rec.mnem = MN_BGEZAL;
            endcase
          end
          default: ;
        endcase
      end
      OP_BEQ, OP_BNE: begin
        rec.valid = 1'b1;
        rec.form  = FORM_RR_TGT;
        rec.reg_a = rs;
        rec.reg_b = rt;
        rec.mnem  = (op == OP_BEQ) ? MN_BEQ : MN_BNE;
      end
      OP_BLEZ, OP_BGTZ: begin
        rec.valid = 1'b1;
        rec.form  = FORM_R_TGT;
        rec.reg_a = rs;
        rec.mnem  = (op == OP_BLEZ) ? MN_BLEZ : MN_BGTZ;
      end
      OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI: begin
        rec.valid = 1'b1;
        rec.form  = FORM_RR_IMM;
        rec.reg_a = rt;
        rec.reg_b = rs;
        case (op)
          OP_ADDI:  rec.mnem = MN_ADDI;
          OP_ADDIU: rec.mnem = MN_ADDIU;
          OP_SLTI:  rec.mnem = MN_SLTI;
          OP_SLTIU: rec.mnem = MN_SLTIU;
          OP_ANDI:  rec.mnem = MN_ANDI;
          OP_ORI:   rec.mnem = MN_ORI;
          default:  rec.mnem = MN_XORI;
        endcase
      end
      OP_LUI: begin
        rec.valid = 1'b1; rec.mnem = MN_LUI; rec.form = FORM_R_IMM; rec.reg_a = rt;
      end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
        rec.valid = 1'b1;
        rec.form  = FORM_MEM;
        rec.reg_a = rt;
        rec.reg_b = rs;
        case (op)
          OP_LB:   rec.mnem = MN_LB;
          OP_LH:   rec.mnem = MN_LH;
          OP_LW:   rec.mnem = MN_LW;
          OP_LBU:  rec.mnem = MN_LBU;
          OP_LHU:  rec.mnem = MN_LHU;
          OP_SB:   rec.mnem = MN_SB;
          OP_SH:   rec.mnem = MN_SH;
          default: rec.mnem = MN_SW;
        endcase
      end
      OP_J, OP_JAL: begin
        rec.valid = 1'b1;
        rec.form  = FORM_TGT;
        rec.mnem  = (op == OP_J) ? MN_J : MN_JAL;
      end
      default: ;
    endcase

    // immediate shown for branch, immediate and memory forms
    if (rec.form == FORM_R_TGT || rec.form == FORM_RR_TGT || rec.form == FORM_RR_IMM ||
        rec.form == FORM_R_IMM || rec.form == FORM_MEM) begin
      rec.imm = instr_word_i[15:0];
    end
  end

  assign rec_o = rec;

endmodule

// File: src/midec_target.sv
// ----------------------------------------------------------------------------
// midec_target: branch and jump target address
// Branches: pc + 4 + sign-extended offset * 4. Jumps: pc region joined with
// the 26-bit index shifted left by two.
// ----------------------------------------------------------------------------
module midec_target (
  input  logic [31:0]        instr_word_i,
  input  logic [31:0]        instr_addr_i,
  input  midec_pkg::form_e   form_i,
  output logic [31:0]        target_o
);
  import midec_pkg::*;

  logic [31:0] offset;
  logic [31:0] branch_tgt;
  logic [31:0] jump_tgt;

  // sign-extended word offset scaled to bytes
  assign offset     = {{14{instr_word_i[15]}}, instr_word_i[15:0], 2'b00};
  assign branch_tgt = instr_addr_i + 32'd4 + offset;
  assign jump_tgt   = (instr_addr_i & JUMP_REGION_MASK) | {4'b0000, instr_word_i[25:0], 2'b00};

  always_comb begin
    case (form_i) inside
      FORM_R_TGT, FORM_RR_TGT: target_o = branch_tgt;
      FORM_TGT:                target_o = jump_tgt;
      default:                 target_o = '0;
    endcase
  end

endmodule

// File: src/mips_instruction_decoder_core.sv
// ----------------------------------------------------------------------------
// mips_instruction_decoder_core: MIPS32 instruction decoder
// Decodes one instruction word and its address into a display record.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries the instruction word and
//   its byte address. Output channel (out_valid_o/out_ready_i) carries one
//   decoded record per input transfer, in order.
//   Path: the input transfer fills the input register; the decode logic
//   then loads the result register, whose valid flag drives out_valid_o.
//   Throughput: one instruction per cycle; the input register and the result
//   register each hold one item, and the input side keeps accepting as long
//   as the result register is free or is drained in the same cycle.
//   Stall: with out_ready_i low the result holds; one more item waits in the
//   input register, after which in_ready_o drops until the result moves.
//   Reset: rst_ni clears both valid flags; no transfer is pending afterwards.
//   Unknown opcodes, functions or REGIMM codes give valid_res_o = 0 with all
//   other fields zero.
// ----------------------------------------------------------------------------
module mips_instruction_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        instr_word_i,
  input  logic [31:0]        instr_addr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               valid_res_o,
  output logic [5:0]         mnemonic_o,
  output logic [3:0]         operand_form_o,
  output logic [4:0]         reg_a_o,
  output logic [4:0]         reg_b_o,
  output logic [4:0]         reg_c_o,
  output logic [4:0]         shift_amount_o,
  output logic signed [15:0] immediate_o,
  output logic [31:0]        target_o
);
  import midec_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic [31:0] word_q;
  logic [31:0] addr_q;
  logic        out_valid_q, out_valid_d;
  dec_rec_t    rec_q;
  logic [31:0] target_q;

  logic        in_xfer;
  logic        s2_free;
  logic        s2_load;
  dec_rec_t    rec;
  logic [31:0] target;

  // Handshake control
  assign s2_free    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign s2_load    = s1_valid_q && s2_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s2_free ? s1_valid_q : out_valid_q;
  end

  // Decode logic
  midec_decode u_decode (
    .instr_word_i (word_q),
    .rec_o        (rec)
  );

  midec_target u_target (
    .instr_word_i (word_q),
    .instr_addr_i (addr_q),
    .form_i       (rec.form),
    .target_o     (target)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      word_q <= instr_word_i;
      addr_q <= instr_addr_i;
    end
    if (s2_load) begin
      rec_q    <= rec;
      target_q <= target;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign valid_res_o    = rec_q.valid;
  assign mnemonic_o     = rec_q.mnem;
  assign operand_form_o = rec_q.form;
  assign reg_a_o        = rec_q.reg_a;
  assign reg_b_o        = rec_q.reg_b;
  assign reg_c_o        = rec_q.reg_c;
  assign shift_amount_o = rec_q.shamt;
  assign immediate_o    = rec_q.imm;
  assign target_o       = target_q;

  // Checks
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a stage is free");

  a_unknown_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (operand_form_o == FORM_NONE && mnemonic_o == MN_SYSCALL && target_o == 32'd0))
    else $error("unknown encoding with nonzero fields");

  a_jump_align : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && operand_form_o == FORM_TGT) |-> (target_o[1:0] == 2'b00))
    else $error("jump target not word aligned");

  a_shamt_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && operand_form_o != FORM_SHAMT) |-> (shift_amount_o == 5'd0))
    else $error("shift amount outside shift form");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for mips_instruction_decoder_core
// Sends instruction words with their addresses over the input channel and
// checks every decoded record against a decoder written here. Covers field
// extremes, branch and jump target wraparound, unknown encodings, every
// mnemonic, and a long random stream. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
  import midec_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_LIMIT = 10000;

  // Expected decode of one instruction
  typedef struct packed {
    logic               valid;
    mnem_e              mnem;
    form_e              form;
    logic [4:0]         reg_a;
    logic [4:0]         reg_b;
    logic [4:0]         reg_c;
    logic [4:0]         shamt;
    logic signed [15:0] imm;
    logic [31:0]        target;
  } decode_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_e;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        in_word;
  logic [31:0]        in_addr;
  logic               out_valid;
  logic               out_ready;
  logic               valid_res;
  logic [5:0]         mnemonic;
  logic [3:0]         operand_form;
  logic [4:0]         reg_a;
  logic [4:0]         reg_b;
  logic [4:0]         reg_c;
  logic [4:0]         shift_amount;
  logic signed [15:0] immediate;
  logic [31:0]        target;

  decode_t  pending_decodes[$];
  decode_t  expected_rec;
  int       mismatch_count;
  int       idle_cycles;
  int       burst_left;
  rx_mode_e rx_mode;
  logic [7:0] rx_count;

  mips_instruction_decoder_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .instr_word_i  (in_word),
    .instr_addr_i  (in_addr),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .valid_res_o   (valid_res),
    .mnemonic_o    (mnemonic),
    .operand_form_o(operand_form),
    .reg_a_o       (reg_a),
    .reg_b_o       (reg_b),
    .reg_c_o       (reg_c),
    .shift_amount_o(shift_amount),
    .immediate_o   (immediate),
    .target_o      (target)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Record with the registers filled in and the valid flag set
  function automatic decode_t with_regs(mnem_e mn, form_e fm, logic [4:0] a,
                                        logic [4:0] b, logic [4:0] c);
    decode_t r;
    r = '0;
    r.valid = 1'b1;
    r.mnem  = mn;
    r.form  = fm;
    r.reg_a = a;
    r.reg_b = b;
    r.reg_c = c;
    return r;
  endfunction

  // Decode of one instruction word at a given address
  function automatic decode_t decode_instr(logic [31:0] w, logic [31:0] pc);
    decode_t     r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [31:0] branch_tgt;
    logic [31:0] jump_tgt;
    r  = '0;
    op = w[31:26];
    rs = w[25:21];
    rt = w[20:16];
    rd = w[15:11];
    sa = w[10:6];
    fn = w[5:0];
    branch_tgt = pc + 32'd4 + {{14{w[15]}}, w[15:0], 2'b00};
    jump_tgt   = (pc & JUMP_REGION_MASK) | {4'd0, w[25:0], 2'b00};
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SYSCALL: r = with_regs(MN_SYSCALL, FORM_NONE, 5'd0, 5'd0, 5'd0);
          FN_MFHI:    r = with_regs(MN_MFHI, FORM_R, rd, 5'd0, 5'd0);
          FN_MFLO:    r = with_regs(MN_MFLO, FORM_R, rd, 5'd0, 5'd0);
          FN_MULT:    r = with_regs(MN_MULT, FORM_RR, rs, rt, 5'd0);
          FN_MULTU:   r = with_regs(MN_MULTU, FORM_RR, rs, rt, 5'd0);
          FN_DIV:     r = with_regs(MN_DIV, FORM_RR, rs, rt, 5'd0);
          FN_DIVU:    r = with_regs(MN_DIVU, FORM_RR, rs, rt, 5'd0);
          FN_ADD:     r = with_regs(MN_ADD, FORM_RRR, rd, rs, rt);
          FN_ADDU:    r = with_regs(MN_ADDU, FORM_RRR, rd, rs, rt);
          FN_SUB:     r = with_regs(MN_SUB, FORM_RRR, rd, rs, rt);
          FN_SUBU:    r = with_regs(MN_SUBU, FORM_RRR, rd, rs, rt);
          FN_AND:     r = with_regs(MN_AND, FORM_RRR, rd, rs, rt);
          FN_OR:      r = with_regs(MN_OR, FORM_RRR, rd, rs, rt);
          FN_XOR:     r = with_regs(MN_XOR, FORM_RRR, rd, rs, rt);
          FN_NOR:     r = with_regs(MN_NOR, FORM_RRR, rd, rs, rt);
          FN_SLT:     r = with_regs(MN_SLT, FORM_RRR, rd, rs, rt);
          FN_SLTU:    r = with_regs(MN_SLTU, FORM_RRR, rd, rs, rt);
          FN_SLL: begin
            r = with_regs(MN_SLL, FORM_SHAMT, rd, rt, 5'd0);
            r.shamt = sa;
          end
          FN_SRL: begin
            r = with_regs(MN_SRL, FORM_SHAMT, rd, rt, 5'd0);
            r.shamt = sa;
          end
          FN_SRA: begin
            r = with_regs(MN_SRA, FORM_SHAMT, rd, rt, 5'd0);
            r.shamt = sa;
          end
          // variable shifts list the shift register last
          FN_SLLV:    r = with_regs(MN_SLLV, FORM_RRR, rd, rt, rs);
          FN_SRLV:    r = with_regs(MN_SRLV, FORM_RRR, rd, rt, rs);
          FN_JR:      r = with_regs(MN_JR, FORM_R, rs, 5'd0, 5'd0);
          default: ;
        endcase
      end
      OP_REGIMM: begin
        case (rt)
          RI_BLTZ:   r = with_regs(MN_BLTZ, FORM_R_TGT, rs, 5'd0, 5'd0);
          RI_BGEZ:   r = with_regs(MN_BGEZ, FORM_R_TGT, rs, 5'd0, 5'd0);
          RI_BLTZAL: r = with_regs(MN_BLTZAL, FORM_R_TGT, rs, 5'd0, 5'd0);
          RI_BGEZAL: r = with_regs(MN_BGEZAL, FORM_R_TGT, rs, 5'd0, 5'd0);
          default: ;
        endcase
      end
      OP_BEQ:   r = with_regs(MN_BEQ, FORM_RR_TGT, rs, rt, 5'd0);
      OP_BNE:   r = with_regs(MN_BNE, FORM_RR_TGT, rs, rt, 5'd0);
      OP_BLEZ:  r = with_regs(MN_BLEZ, FORM_R_TGT, rs, 5'd0, 5'd0);
      OP_BGTZ:  r = with_regs(MN_BGTZ, FORM_R_TGT, rs, 5'd0, 5'd0);
      OP_ADDI:  r = with_regs(MN_ADDI, FORM_RR_IMM, rt, rs, 5'd0);
      OP_ADDIU: r = with_regs(MN_ADDIU, FORM_RR_IMM, rt, rs, 5'd0);
      OP_SLTI:  r = with_regs(MN_SLTI, FORM_RR_IMM, rt, rs, 5'd0);
      OP_SLTIU: r = with_regs(MN_SLTIU, FORM_RR_IMM, rt, rs, 5'd0);
      OP_ANDI:  r = with_regs(MN_ANDI, FORM_RR_IMM, rt, rs, 5'd0);
      OP_ORI:   r = with_regs(MN_ORI, FORM_RR_IMM, rt, rs, 5'd0);
      OP_XORI:  r = with_regs(MN_XORI, FORM_RR_IMM, rt, rs, 5'd0);
      OP_LUI:   r = with_regs(MN_LUI, FORM_R_IMM, rt, 5'd0, 5'd0);
      OP_LB:    r = with_regs(MN_LB, FORM_MEM, rt, rs, 5'd0);
      OP_LH:    r = with_regs(MN_LH, FORM_MEM, rt, rs, 5'd0);
      OP_LW:    r = with_regs(MN_LW, FORM_MEM, rt, rs, 5'd0);
      OP_LBU:   r = with_regs(MN_LBU, FORM_MEM, rt, rs, 5'd0);
      OP_LHU:   r = with_regs(MN_LHU, FORM_MEM, rt, rs, 5'd0);
      OP_SB:    r = with_regs(MN_SB, FORM_MEM, rt, rs, 5'd0);
      OP_SH:    r = with_regs(MN_SH, FORM_MEM, rt, rs, 5'd0);
      OP_SW:    r = with_regs(MN_SW, FORM_MEM, rt, rs, 5'd0);
      OP_J:     r = with_regs(MN_J, FORM_TGT, 5'd0, 5'd0, 5'd0);
      OP_JAL:   r = with_regs(MN_JAL, FORM_TGT, 5'd0, 5'd0, 5'd0);
      default: ;
    endcase
    // immediate and target only where the form shows them
    if (r.valid) begin
      if (r.form >= FORM_R_TGT && r.form <= FORM_MEM) r.imm = w[15:0];
      if (r.form == FORM_R_TGT || r.form == FORM_RR_TGT) r.target = branch_tgt;
      else if (r.form == FORM_TGT) r.target = jump_tgt;
    end
    return r;
  endfunction

  // Word for a given mnemonic; the other bits come from fill
  function automatic logic [31:0] encode_op(mnem_e mn, logic [31:0] fill);
    logic [31:0] w;
    w = fill;
    case (mn)
      MN_SYSCALL: w = {OP_SPECIAL, fill[25:6], FN_SYSCALL};
      MN_MFHI:    w = {OP_SPECIAL, fill[25:6], FN_MFHI};
      MN_MFLO:    w = {OP_SPECIAL, fill[25:6], FN_MFLO};
      MN_MULT:    w = {OP_SPECIAL, fill[25:6], FN_MULT};
      MN_MULTU:   w = {OP_SPECIAL, fill[25:6], FN_MULTU};
      MN_DIV:     w = {OP_SPECIAL, fill[25:6], FN_DIV};
      MN_DIVU:    w = {OP_SPECIAL, fill[25:6], FN_DIVU};
      MN_ADD:     w = {OP_SPECIAL, fill[25:6], FN_ADD};
      MN_ADDU:    w = {OP_SPECIAL, fill[25:6], FN_ADDU};
      MN_SUB:     w = {OP_SPECIAL, fill[25:6], FN_SUB};
      MN_SUBU:    w = {OP_SPECIAL, fill[25:6], FN_SUBU};
      MN_AND:     w = {OP_SPECIAL, fill[25:6], FN_AND};
      MN_OR:      w = {OP_SPECIAL, fill[25:6], FN_OR};
      MN_XOR:     w = {OP_SPECIAL, fill[25:6], FN_XOR};
      MN_NOR:     w = {OP_SPECIAL, fill[25:6], FN_NOR};
      MN_SLT:     w = {OP_SPECIAL, fill[25:6], FN_SLT};
      MN_SLTU:    w = {OP_SPECIAL, fill[25:6], FN_SLTU};
      MN_SLL:     w = {OP_SPECIAL, fill[25:6], FN_SLL};
      MN_SRL:     w = {OP_SPECIAL, fill[25:6], FN_SRL};
      MN_SRA:     w = {OP_SPECIAL, fill[25:6], FN_SRA};
      MN_SLLV:    w = {OP_SPECIAL, fill[25:6], FN_SLLV};
      MN_SRLV:    w = {OP_SPECIAL, fill[25:6], FN_SRLV};
      MN_JR:      w = {OP_SPECIAL, fill[25:6], FN_JR};
      MN_BLTZ:    w = {OP_REGIMM, fill[25:21], RI_BLTZ, fill[15:0]};
      MN_BGEZ:    w = {OP_REGIMM, fill[25:21], RI_BGEZ, fill[15:0]};
      MN_BLTZAL:  w = {OP_REGIMM, fill[25:21], RI_BLTZAL, fill[15:0]};
      MN_BGEZAL:  w = {OP_REGIMM, fill[25:21], RI_BGEZAL, fill[15:0]};
      MN_BEQ:     w = {OP_BEQ, fill[25:0]};
      MN_BNE:     w = {OP_BNE, fill[25:0]};
      MN_BLEZ:    w = {OP_BLEZ, fill[25:0]};
      MN_BGTZ:    w = {OP_BGTZ, fill[25:0]};
      MN_ADDI:    w = {OP_ADDI, fill[25:0]};
      MN_ADDIU:   w = {OP_ADDIU, fill[25:0]};
      MN_SLTI:    w = {OP_SLTI, fill[25:0]};
      MN_SLTIU:   w = {OP_SLTIU, fill[25:0]};
      MN_ANDI:    w = {OP_ANDI, fill[25:0]};
      MN_ORI:     w = {OP_ORI, fill[25:0]};
      MN_XORI:    w = {OP_XORI, fill[25:0]};
      MN_LUI:     w = {OP_LUI, fill[25:0]};
      MN_LB:      w = {OP_LB, fill[25:0]};
      MN_LH:      w = {OP_LH, fill[25:0]};
      MN_LW:      w = {OP_LW, fill[25:0]};
      MN_LBU:     w = {OP_LBU, fill[25:0]};
      MN_LHU:     w = {OP_LHU, fill[25:0]};
      MN_SB:      w = {OP_SB, fill[25:0]};
      MN_SH:      w = {OP_SH, fill[25:0]};
      MN_SW:      w = {OP_SW, fill[25:0]};
      MN_J:       w = {OP_J, fill[25:0]};
      MN_JAL:     w = {OP_JAL, fill[25:0]};
      default: ;
    endcase
    return w;
  endfunction

  // Address mix: anywhere, near zero, near the top, near a jump region edge
  function automatic logic [31:0] rand_addr();
    logic [31:0] a;
    case ($urandom_range(0, 3))
      0:       a = $urandom;
      1:       a = $urandom_range(0, 64);
      2:       a = 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: a = ($urandom & JUMP_REGION_MASK) | 32'h0FFF_FFF0 | ($urandom & 32'hF);
    endcase
    return a;
  endfunction

  // Send one instruction; the sender runs in bursts, mostly with gaps between them
  task automatic issue_instr(logic [31:0] w, logic [31:0] a);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    in_addr  <= a;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_decodes.insert(pending_decodes.size(), decode_instr(w, a));
  endtask

  // Hold the sender off until every decode has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_decodes.size() != 0);
    burst_left = 0;
  endtask

  task automatic test_field_extremes();
    issue_instr(32'h0000_0000, 32'h0000_0000);
    issue_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_instr({OP_SPECIAL, 20'hFFFFF, FN_SRA}, $urandom);
    issue_instr({OP_SPECIAL, 20'h00000, FN_SYSCALL}, 32'hFFFF_FFFF);
    issue_instr({OP_SPECIAL, 20'hFFFFF, FN_SYSCALL}, $urandom);
    issue_instr({OP_ADDI, 5'd31, 5'd0, 16'h7FFF}, $urandom);
    issue_instr({OP_ADDIU, 5'd0, 5'd31, 16'h8000}, $urandom);
    // logical immediates come back in the same signed field, not zero-extended
    issue_instr({OP_ANDI, 5'd7, 5'd9, 16'hFFFF}, $urandom);
    issue_instr({OP_LUI, 5'd31, 5'd31, 16'h8000}, $urandom);
    issue_instr({OP_SW, 5'd31, 5'd31, 16'hFFFF}, 32'h8000_0000);
  endtask

  task automatic test_target_wrap();
    issue_instr({OP_BEQ, 5'd1, 5'd2, 16'h7FFF}, 32'hFFFF_FFFC);
    issue_instr({OP_BNE, 5'd31, 5'd31, 16'h8000}, 32'h0000_0000);
    issue_instr({OP_REGIMM, 5'd3, RI_BGEZAL, 16'hFFFF}, 32'h0000_0000);
    issue_instr({OP_REGIMM, 5'd0, RI_BLTZ, 16'h0000}, 32'h7FFF_FFFC);
    issue_instr({OP_J, 26'h3FF_FFFF}, 32'hF000_0000);
    issue_instr({OP_JAL, 26'h000_0000}, 32'hFFFF_FFFF);
    issue_instr({OP_J, 26'h200_0001}, 32'h0FFF_FFFC);
  endtask

  task automatic test_unknown_encodings();
    issue_instr({OP_SPECIAL, 20'hABCDE, 6'd1}, $urandom);
    issue_instr({OP_SPECIAL, 20'h00000, 6'd63}, $urandom);
    issue_instr({OP_REGIMM, 5'd4, 5'd2, 16'h1234}, $urandom);
    issue_instr({OP_REGIMM, 5'd31, 5'd31, 16'hFFFF}, $urandom);
    issue_instr({6'd16, 26'h155_5555}, $urandom);
    issue_instr({6'd44, 26'h2AA_AAAA}, $urandom);
  endtask

  task automatic test_every_operation();
    for (int m = 0; m <= 48; m++) issue_instr(encode_op(mnem_e'(m), $urandom), rand_addr());
  endtask

  // Mostly well-formed instructions, the rest raw noise
  task automatic test_random_decode(int count);
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) w = encode_op(mnem_e'($urandom_range(0, 48)), $urandom);
      else w = $urandom;
      issue_instr(w, rand_addr());
    end
  endtask

  // Near misses: SPECIAL with any funct, REGIMM with any rt, any opcode
  task automatic test_malformed(int count);
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      w = $urandom;
      case ($urandom_range(0, 2))
        0:       w[31:26] = OP_SPECIAL;
        1:       w[31:26] = OP_REGIMM;
        default: ;
      endcase
      issue_instr(w, rand_addr());
    end
  endtask

  // Stimulus
  initial begin
    logic timed_out;
    int   waited;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_word    <= '0;
    in_addr    <= '0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_target_wrap();
    wait_for_drain();
    test_unknown_encodings();
    test_every_operation();
    wait_for_drain();
    test_random_decode(1100);
    wait_for_drain();
    test_malformed(180);

    // let everything come back or time out, then stay quiet before the verdict
    in_valid <= 1'b0;
    waited = 0;
    timed_out = 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_decodes.size() != 0 && waited < DRAIN_LIMIT);
    if (pending_decodes.size() != 0) timed_out = 1'b1;
    if (timed_out) begin
      $display("mips_instruction_decoder_core test failed");
    end else begin
      repeat (6) @(posedge clk);
      if (mismatch_count == 0) begin
        $display("mips_instruction_decoder_core test passed");
      end else begin
        $display("mips_instruction_decoder_core test failed");
      end
    end
    $finish;
  end

  // Receiver stall pattern, picked anew each time the 8-bit rx_count wraps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_count  <= '0;
      rx_mode   <= RX_FREE;
    end else begin
      rx_count <= rx_count + 8'd1;
      if (rx_count == 8'hFF) rx_mode <= rx_mode_e'($urandom_range(0, 3));
      case (rx_mode)
        RX_FREE:     out_ready <= 1'b1;
        RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
        RX_SLOW:     out_ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ready <= (rx_count[2:0] != 3'd6);
        default:     out_ready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Result checker: outputs are stable at the falling edge before the transfer
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t: result with none expected, expected none, actual mnemonic %h",
                 $time, mnemonic);
        mismatch_count++;
      end else begin
        expected_rec = pending_decodes.pop_front();
        check_field("valid_res", 32'(expected_rec.valid), 32'(valid_res));
        check_field("mnemonic", 32'(expected_rec.mnem), 32'(mnemonic));
        check_field("operand_form", 32'(expected_rec.form), 32'(operand_form));
        check_field("reg_a", 32'(expected_rec.reg_a), 32'(reg_a));
        check_field("reg_b", 32'(expected_rec.reg_b), 32'(reg_b));
        check_field("reg_c", 32'(expected_rec.reg_c), 32'(reg_c));
        check_field("shift_amount", 32'(expected_rec.shamt), 32'(shift_amount));
        check_field("immediate", {16'h0, expected_rec.imm}, {16'h0, immediate});
        check_field("target", expected_rec.target, target);
      end
    end
  end

  // Watchdog: too long with no transfer on either channel
  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("mips_instruction_decoder_core test failed");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
src/midec_pkg.sv
src/midec_decode.sv
src/midec_target.sv
src/mips_instruction_decoder_core.sv
sim/tb.sv
